[hdl/sfp_pkg.sv]
// sfp_pkg: shared types and constants for the sync / follow-up pairing block
// used by sfp_front, sfp_queue, sfp_back and sync_follow_up_pairing
// no dependencies
package sfp_pkg;

  // nanoseconds in one second, as a 30-bit constant
  localparam logic [29:0] NS_PER_SEC = 30'd1000000000;
  // scaled correction fraction bits
  localparam int unsigned CORR_SHIFT = 16;
  // seconds are multiplied in two halves of this many bits
  localparam int unsigned SEC_SPLIT = 24;

  // configuration register indexes
  localparam logic REG_RECEIVER_STATE = 1'b0;
  localparam logic REG_PATH_ASYM      = 1'b1;

  // message kinds
  localparam logic MSG_SYNC      = 1'b0;
  localparam logic MSG_FOLLOW_UP = 1'b1;

  // one received message
  typedef struct packed {
    logic               action;
    logic               two_step;
    logic               from_parent;
    logic [15:0]        sequence_number;
    logic [47:0]        host_seconds;
    logic [29:0]        host_nanoseconds;
    logic [47:0]        origin_seconds;
    logic [29:0]        origin_nanoseconds;
    logic signed [63:0] correction;
  } msg_t;

  // one synchronisation result
  typedef struct packed {
    logic        sample_valid;
    logic [63:0] ingress_time;
    logic [63:0] corrected_origin_time;
  } result_t;

  // job handed from the front to the back: operands already selected,
  // all zero when no sample is produced
  typedef struct packed {
    logic        sample_valid;
    logic [47:0] host_seconds;
    logic [29:0] host_nanoseconds;
    logic [47:0] origin_seconds;
    logic [29:0] origin_nanoseconds;
    logic [63:0] corr_a;
    logic [63:0] corr_b;
  } job_t;

endpackage

[hdl/sfp_front.sv]
// sfp_front: configuration registers, message filtering and sync / follow-up pairing
// holds the single pending message and emits one job per accepted transaction
// depends on sfp_pkg
module sfp_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [63:0]       cfg_data,
  input  logic              accept,
  input  sfp_pkg::msg_t     msg,
  output sfp_pkg::job_t     job
);

  logic        receiver_state;
  logic [63:0] path_asym;

  logic        held_valid;
  logic        held_is_follow_up;
  logic [15:0] held_sequence;
  logic [47:0] held_host_seconds;
  logic [29:0] held_host_nanoseconds;
  logic [47:0] held_origin_seconds;
  logic [29:0] held_origin_nanoseconds;
  logic [63:0] held_correction;

  logic        taken;
  logic        one_step;
  logic        paired;
  logic [63:0] corr_adj;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      receiver_state <= 1'b0;
      path_asym      <= 64'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        sfp_pkg::REG_RECEIVER_STATE: receiver_state <= cfg_data[0];
        sfp_pkg::REG_PATH_ASYM:      path_asym      <= cfg_data;
        default: ;
      endcase
    end
  end

  // classification of the incoming message
  always_comb begin
    taken    = receiver_state && msg.from_parent;
    corr_adj = (msg.action == sfp_pkg::MSG_SYNC) ?
               64'(msg.correction) + path_asym : 64'(msg.correction);
    one_step = (msg.action == sfp_pkg::MSG_SYNC) && !msg.two_step;
    paired   = held_valid && (msg.sequence_number == held_sequence) &&
               (held_is_follow_up != msg.action);
  end

  // operand selection for the arithmetic back end
  always_comb begin
    job = '0;
    if (taken && one_step) begin
      job.sample_valid       = 1'b1;
      job.host_seconds       = msg.host_seconds;
      job.host_nanoseconds   = msg.host_nanoseconds;
      job.origin_seconds     = msg.origin_seconds;
      job.origin_nanoseconds = msg.origin_nanoseconds;
      job.corr_a             = corr_adj;
    end else if (taken && paired) begin
      job.sample_valid = 1'b1;
      job.corr_a       = corr_adj;
      job.corr_b       = held_correction;
      if (msg.action == sfp_pkg::MSG_FOLLOW_UP) begin
        job.host_seconds       = held_host_seconds;
        job.host_nanoseconds   = held_host_nanoseconds;
        job.origin_seconds     = msg.origin_seconds;
        job.origin_nanoseconds = msg.origin_nanoseconds;
      end else begin
        job.host_seconds       = msg.host_seconds;
        job.host_nanoseconds   = msg.host_nanoseconds;
        job.origin_seconds     = held_origin_seconds;
        job.origin_nanoseconds = held_origin_nanoseconds;
      end
    end
  end

  // pending message validity
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (accept && taken) begin
      held_valid <= !(one_step || paired);
    end
  end

  // pending message contents, replaced by any unmatched two-step message
  always_ff @(posedge clk) begin
    if (accept && taken && !one_step && !paired) begin
      held_is_follow_up       <= msg.action;
      held_sequence           <= msg.sequence_number;
      held_host_seconds       <= msg.host_seconds;
      held_host_nanoseconds   <= msg.host_nanoseconds;
      held_origin_seconds     <= msg.origin_seconds;
      held_origin_nanoseconds <= msg.origin_nanoseconds;
      held_correction         <= corr_adj;
    end
  end

endmodule

[hdl/sfp_queue.sv]
// sfp_queue: short first-in first-out queue of jobs between front and back
// flip-flop storage, read data taken from the head entry
// depends on sfp_pkg
module sfp_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  sfp_pkg::job_t  push_data,
  input  logic           pop,
  output sfp_pkg::job_t  head,
  output logic           full,
  output logic           empty
);

  localparam int unsigned PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned COUNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0]   LAST_PTR  = PTR_W'(DEPTH - 1);
  localparam logic [COUNT_W-1:0] FULL_CNT  = COUNT_W'(DEPTH);

  sfp_pkg::job_t      entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [COUNT_W-1:0] count;

  assign full  = (count == FULL_CNT);
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + COUNT_W'(1);
      end else if (pop && !push) begin
        count <= count - COUNT_W'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

[hdl/sfp_back.sv]
// sfp_back: two-stage arithmetic pipeline turning jobs into nanosecond results
// stage one forms the seconds partial products, stage two sums into the result register
// depends on sfp_pkg
module sfp_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_ready,
  input  sfp_pkg::job_t     job,
  output logic              job_pop,
  output logic              result_valid,
  input  logic              result_stall,
  output sfp_pkg::result_t  result
);

  localparam int unsigned HI_W   = 48 - sfp_pkg::SEC_SPLIT;
  localparam int unsigned PROD_W = sfp_pkg::SEC_SPLIT + 30;
  localparam int unsigned PHI_W  = HI_W + 30;

  logic advance;

  logic              s1_valid;
  logic              s1_sample;
  logic [PROD_W-1:0] s1_ing_lo;
  logic [PHI_W-1:0]  s1_ing_hi;
  logic [29:0]       s1_ing_ns;
  logic [PROD_W-1:0] s1_org_lo;
  logic [PHI_W-1:0]  s1_org_hi;
  logic [63:0]       s1_org_rest;

  logic [63:0] corr_a_shr;
  logic [63:0] corr_b_shr;
  logic [63:0] ingress_next;
  logic [63:0] origin_next;

  // the pipeline moves whenever the result register is free or being taken
  assign advance = !result_valid || !result_stall;
  assign job_pop = advance && job_ready;

  // arithmetic shift of the scaled corrections to whole nanoseconds
  assign corr_a_shr = 64'($signed(job.corr_a) >>> sfp_pkg::CORR_SHIFT);
  assign corr_b_shr = 64'($signed(job.corr_b) >>> sfp_pkg::CORR_SHIFT);

  // stage one valid
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= job_ready;
    end
  end

  // stage one: seconds times 1e9 in two halves, origin remainder summed
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_sample   <= job.sample_valid;
      s1_ing_lo   <= PROD_W'(job.host_seconds[sfp_pkg::SEC_SPLIT-1:0]) *
                     PROD_W'(sfp_pkg::NS_PER_SEC);
      s1_ing_hi   <= PHI_W'(job.host_seconds[47:sfp_pkg::SEC_SPLIT]) *
                     PHI_W'(sfp_pkg::NS_PER_SEC);
      s1_ing_ns   <= job.host_nanoseconds;
      s1_org_lo   <= PROD_W'(job.origin_seconds[sfp_pkg::SEC_SPLIT-1:0]) *
                     PROD_W'(sfp_pkg::NS_PER_SEC);
      s1_org_hi   <= PHI_W'(job.origin_seconds[47:sfp_pkg::SEC_SPLIT]) *
                     PHI_W'(sfp_pkg::NS_PER_SEC);
      s1_org_rest <= 64'(job.origin_nanoseconds) + corr_a_shr + corr_b_shr;
    end
  end

  // stage two: recombine the halves, modulo 2^64
  assign ingress_next = 64'({s1_ing_hi, {sfp_pkg::SEC_SPLIT{1'b0}}}) +
                        64'(s1_ing_lo) + 64'(s1_ing_ns);
  assign origin_next  = 64'({s1_org_hi, {sfp_pkg::SEC_SPLIT{1'b0}}}) +
                        64'(s1_org_lo) + s1_org_rest;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.sample_valid          <= s1_sample;
      result.ingress_time          <= ingress_next;
      result.corrected_origin_time <= origin_next;
    end
  end

endmodule

[hdl/sync_follow_up_pairing.sv]
// sync_follow_up_pairing: top level of the two-step sync / follow-up pairing block
// connects the pairing front end, the job queue and the arithmetic back end
// depends on sfp_pkg, sfp_front, sfp_queue, sfp_back

// Every accepted message transaction yields exactly one result transaction, in
// order; sample_valid is clear (and both times zero) when the message was
// ignored or only stored for pairing. The block takes one message per clock
// cycle while msg_stall is low: the pairing decision and the update of the
// held message complete in the cycle of acceptance. A result passes through
// the queue entry, written at acceptance, then the multiply stage and the sum
// stage of the back end. The queue of QUEUE_DEPTH jobs lets the front keep
// taking messages while results wait; msg_stall rises only when it is full.
// Configuration writes take effect on the next message.
module sync_follow_up_pairing #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [63:0]       cfg_data,
  input  logic              msg_valid,
  output logic              msg_stall,
  input  sfp_pkg::msg_t     msg,
  output logic              result_valid,
  input  logic              result_stall,
  output sfp_pkg::result_t  result
);

  logic          accept;
  logic          q_full;
  logic          q_empty;
  logic          q_pop;
  sfp_pkg::job_t front_job;
  sfp_pkg::job_t head_job;

  assign msg_stall = q_full;
  assign accept    = msg_valid && !q_full;

  // pairing front end
  sfp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .msg       (msg),
    .job       (front_job)
  );

  // job queue
  sfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (front_job),
    .pop       (q_pop),
    .head      (head_job),
    .full      (q_full),
    .empty     (q_empty)
  );

  // arithmetic back end
  sfp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .job_ready    (!q_empty),
    .job          (head_job),
    .job_pop      (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

[tb/sv/sync_follow_up_pairing_test.sv]
// sync_follow_up_pairing_test: self-checking bench for the sync / follow-up pairing block
// directed table then random message streams, each result checked against the table or a local predictor
// depends on sfp_pkg and sync_follow_up_pairing
module sync_follow_up_pairing_test;

  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned HOLD_LEN = 60;
  localparam int unsigned TAIL_CYCLES = 20;
  localparam sfp_pkg::result_t NO_SAMPLE = '0;

  typedef enum logic {ROW_WRITE, ROW_MSG} row_kind_t;

  typedef struct {
    row_kind_t        kind;
    logic             index;
    logic [63:0]      data;
    sfp_pkg::msg_t    m;
    bit               fixed;
    sfp_pkg::result_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic cfg_index;
  logic [63:0] cfg_data;
  logic msg_valid;
  logic msg_stall;
  sfp_pkg::msg_t msg;
  logic result_valid;
  logic result_stall;
  sfp_pkg::result_t result;

  // expectation typed into the table, travelling with the message transaction
  logic row_fixed;
  sfp_pkg::result_t row_want;

  sfp_pkg::result_t pending_samples[$];
  dir_row_t directed[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit quiet = 1'b0;
  bit long_hold = 1'b0;

  // predictor copy of the registers and the held message
  logic        rx_on;
  logic [63:0] asym;
  logic        held_ok;
  logic        held_fup;
  logic [15:0] held_seq;
  logic [47:0] held_host_s;
  logic [29:0] held_host_ns;
  logic [47:0] held_orig_s;
  logic [29:0] held_orig_ns;
  logic [63:0] held_corr;

  always #5 clk = ~clk;

  sync_follow_up_pairing dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .msg_valid(msg_valid),
    .msg_stall(msg_stall),
    .msg(msg),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  // scaled nanoseconds to whole nanoseconds, rounding towards minus infinity
  function automatic logic [63:0] whole_ns(logic [63:0] c);
    logic signed [63:0] s;
    s = c;
    return s >>> sfp_pkg::CORR_SHIFT;
  endfunction

  function automatic sfp_pkg::result_t make_sample(logic [47:0] hs, logic [29:0] hn,
                                                   logic [47:0] os, logic [29:0] on_ns,
                                                   logic [63:0] c1, logic [63:0] c2);
    sfp_pkg::result_t r;
    r.sample_valid = 1'b1;
    r.ingress_time = 64'(hs) * 64'(sfp_pkg::NS_PER_SEC) + 64'(hn);
    r.corrected_origin_time = 64'(os) * 64'(sfp_pkg::NS_PER_SEC) + 64'(on_ns) +
                              whole_ns(c1) + whole_ns(c2);
    return r;
  endfunction

  // pairing decision for one accepted message, updating the held copy
  function automatic sfp_pkg::result_t predict_sample(sfp_pkg::msg_t m);
    sfp_pkg::result_t r;
    logic [63:0] c;
    logic is_fup;
    r = NO_SAMPLE;
    is_fup = (m.action == sfp_pkg::MSG_FOLLOW_UP);
    if (!rx_on || !m.from_parent) return r;
    c = m.correction;
    if (!is_fup) begin
      c = c + asym;
      if (!m.two_step) begin
        held_ok = 1'b0;
        return make_sample(m.host_seconds, m.host_nanoseconds, m.origin_seconds,
                           m.origin_nanoseconds, c, 64'd0);
      end
    end
    if (held_ok && m.sequence_number == held_seq && held_fup != is_fup) begin
      held_ok = 1'b0;
      if (is_fup) begin
        return make_sample(held_host_s, held_host_ns, m.origin_seconds, m.origin_nanoseconds,
                           held_corr, c);
      end
      return make_sample(m.host_seconds, m.host_nanoseconds, held_orig_s, held_orig_ns,
                         c, held_corr);
    end
    held_ok = 1'b1;
    held_fup = is_fup;
    held_seq = m.sequence_number;
    held_host_s = m.host_seconds;
    held_host_ns = m.host_nanoseconds;
    held_orig_s = m.origin_seconds;
    held_orig_ns = m.origin_nanoseconds;
    held_corr = c;
    return r;
  endfunction

  // monitor: result check, register writes, message prediction and watchdog
  always @(posedge clk) begin
    sfp_pkg::result_t want;
    bit took;
    took = 1'b0;
    if (rst) begin
      rx_on = 1'b0;
      asym = '0;
      held_ok = 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        took = 1'b1;
        if (pending_samples.size() == 0) begin
          $error("result transaction with no expectation waiting");
          mismatches++;
        end else begin
          want = pending_samples.pop_front();
          if (result.sample_valid !== want.sample_valid) begin
            $error("sample_valid: expected %0d, got %0d", want.sample_valid,
                   result.sample_valid);
            mismatches++;
          end
          if (result.ingress_time !== want.ingress_time) begin
            $error("ingress_time: expected %h, got %h", want.ingress_time,
                   result.ingress_time);
            mismatches++;
          end
          if (result.corrected_origin_time !== want.corrected_origin_time) begin
            $error("corrected_origin_time: expected %h, got %h", want.corrected_origin_time,
                   result.corrected_origin_time);
            mismatches++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          sfp_pkg::REG_RECEIVER_STATE: rx_on = cfg_data[0];
          sfp_pkg::REG_PATH_ASYM: asym = cfg_data;
          default: ;
        endcase
      end
      if (msg_valid && !msg_stall) begin
        took = 1'b1;
        want = predict_sample(msg);
        if (row_fixed) want = row_want;
        pending_samples.push_back(want);
      end
    end
    if (rst || took) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("sync_follow_up_pairing_test: FAIL");
      $finish;
    end
  end

  // receiver side: short random stalls, or one long hold-off on request
  initial begin
    result_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        result_stall <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
        result_stall <= 1'b0;
        long_hold = 1'b0;
      end else if (!quiet && !rst && $urandom_range(0, 5) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  function automatic sfp_pkg::msg_t mk(logic act, logic ts, logic par, logic [15:0] seq,
                                       logic [47:0] hs, logic [29:0] hn, logic [47:0] os,
                                       logic [29:0] on_ns, logic [63:0] c);
    sfp_pkg::msg_t m;
    m.action = act;
    m.two_step = ts;
    m.from_parent = par;
    m.sequence_number = seq;
    m.host_seconds = hs;
    m.host_nanoseconds = hn;
    m.origin_seconds = os;
    m.origin_nanoseconds = on_ns;
    m.correction = c;
    return m;
  endfunction

  function automatic void add_msg(sfp_pkg::msg_t m);
    directed.push_back('{ROW_MSG, sfp_pkg::REG_RECEIVER_STATE, 64'd0, m, 1'b0, NO_SAMPLE});
  endfunction

  function automatic void add_fixed(sfp_pkg::msg_t m, sfp_pkg::result_t r);
    directed.push_back('{ROW_MSG, sfp_pkg::REG_RECEIVER_STATE, 64'd0, m, 1'b1, r});
  endfunction

  function automatic void add_write(logic idx, logic [63:0] d);
    directed.push_back('{ROW_WRITE, idx, d, sfp_pkg::msg_t'('0), 1'b0, NO_SAMPLE});
  endfunction

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [47:0] rand_secs();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 48'($urandom_range(0, 100000));
      3: return 48'($urandom_range(1600000000, 2000000000));
      default: return 48'(rand_word());
    endcase
  endfunction

  function automatic logic [29:0] rand_ns();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 30'd999_999_999;
      2: return '1;
      3: return 30'($urandom);
      default: return 30'($urandom_range(0, 999_999_999));
    endcase
  endfunction

  function automatic logic [63:0] rand_corr();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 64'h7FFF_FFFF_FFFF_FFFF;
      2: return 64'h8000_0000_0000_0000;
      3: return '1;
      4: return 64'(signed'($urandom_range(0, 2000000)) - 1000000) << sfp_pkg::CORR_SHIFT;
      default: return rand_word();
    endcase
  endfunction

  function automatic sfp_pkg::msg_t rand_msg(logic act, logic ts, logic [15:0] seq);
    return mk(act, ts, 1'b1, seq, rand_secs(), rand_ns(), rand_secs(), rand_ns(), rand_corr());
  endfunction

  // offer one message transaction, with an occasional gap before it
  task automatic offer_message(sfp_pkg::msg_t m, bit fixed, sfp_pkg::result_t want);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      msg_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    msg <= m;
    row_fixed <= fixed;
    row_want <= want;
    msg_valid <= 1'b1;
    @(posedge clk);
    while (msg_stall) @(posedge clk);
  endtask

  task automatic send(sfp_pkg::msg_t m);
    offer_message(m, 1'b0, NO_SAMPLE);
  endtask

  // stop offering until every expected result has come back
  task automatic drain();
    msg_valid <= 1'b0;
    do @(posedge clk); while (pending_samples.size() != 0);
  endtask

  task automatic write_reg(logic idx, logic [63:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // mostly well-formed sync / follow-up pairs, with noise and broken pairs mixed in
  task automatic run_random(int n);
    sfp_pkg::msg_t a, b, tmp;
    logic [255:0] bits;
    int sent;
    int pick;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        a = rand_msg(sfp_pkg::MSG_SYNC, 1'b1, 16'($urandom));
        b = rand_msg(sfp_pkg::MSG_FOLLOW_UP, 1'($urandom), a.sequence_number);
        if ($urandom_range(0, 2) == 0) begin
          tmp = a;
          a = b;
          b = tmp;
        end
        send(a);
        if ($urandom_range(0, 9) == 0) begin
          tmp = rand_msg(1'($urandom), 1'($urandom), a.sequence_number);
          tmp.from_parent = 1'b0;
          send(tmp);
          sent++;
        end
        send(b);
        sent += 2;
      end else if (pick < 70) begin
        send(rand_msg(sfp_pkg::MSG_SYNC, 1'b0, 16'($urandom)));
        sent++;
      end else if (pick < 82) begin
        a = rand_msg(1'($urandom), 1'b1, 16'($urandom));
        b = rand_msg(!a.action, 1'b1, a.sequence_number + 16'd1);
        if ($urandom_range(0, 1) == 0) begin
          b.action = a.action;
          b.sequence_number = a.sequence_number;
        end
        send(a);
        send(b);
        sent += 2;
      end else if (pick < 90) begin
        tmp = rand_msg(1'($urandom), 1'($urandom), 16'($urandom));
        tmp.from_parent = 1'b0;
        send(tmp);
        sent++;
      end else begin
        bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        send(sfp_pkg::msg_t'(bits[$bits(sfp_pkg::msg_t)-1:0]));
        sent++;
      end
    end
  endtask

  // main sequence
  initial begin
    dir_row_t row;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = sfp_pkg::REG_RECEIVER_STATE;
    cfg_data = '0;
    msg_valid = 1'b0;
    msg = '0;
    row_fixed = 1'b0;
    row_want = NO_SAMPLE;

    // port not receiving: everything ignored
    add_fixed(mk(sfp_pkg::MSG_SYNC, 1'b0, 1'b1, 16'h0001, '1, '1, '1, '1, '1), NO_SAMPLE);
    add_fixed(mk(sfp_pkg::MSG_FOLLOW_UP, 1'b1, 1'b1, 16'h0001, 48'd5, 30'd5, 48'd5, 30'd5,
                 64'd0), NO_SAMPLE);
    add_write(sfp_pkg::REG_RECEIVER_STATE, 64'd1);
    // one-step syncs: foreign sender, zeros, simple values, extremes
    add_fixed(mk(sfp_pkg::MSG_SYNC, 1'b0, 1'b0, 16'h0002, '1, 30'd1, 48'd1, 30'd1, 64'd0),
              NO_SAMPLE);
    add_fixed(mk(sfp_pkg::MSG_SYNC, 1'b0, 1'b1, 16'h0000, '0, '0, '0, '0, '0),
              '{1'b1, 64'd0, 64'd0});
    add_fixed(mk(sfp_pkg::MSG_SYNC, 1'b0, 1'b1, 16'h0003, 48'd1, 30'd0, 48'd2, 30'd5,
                 64'h3_0000), '{1'b1, 64'd1_000_000_000, 64'd2_000_000_008});
    add_fixed(mk(sfp_pkg::MSG_SYNC, 1'b0, 1'b1, 16'h0004, '0, '0, '0, '0, '1),
              '{1'b1, 64'd0, '1});
    add_msg(mk(sfp_pkg::MSG_SYNC, 1'b0, 1'b1, 16'hFFFF, '1, '1, '1, 30'd999_999_999,
               64'h7FFF_FFFF_FFFF_FFFF));
    add_msg(mk(sfp_pkg::MSG_SYNC, 1'b0, 1'b1, 16'h8000, 48'd77, 30'd999_999_999, 48'd12,
               30'd3, 64'h8000_0000_0000_0000));
    // sync then follow-up
    add_fixed(mk(sfp_pkg::MSG_SYNC, 1'b1, 1'b1, 16'h1234, 48'd100, 30'd7, 48'd0, 30'd0,
                 64'h5_8000), NO_SAMPLE);
    add_msg(mk(sfp_pkg::MSG_FOLLOW_UP, 1'b0, 1'b1, 16'h1234, 48'd0, 30'd0, 48'd99, 30'd900,
               64'hFFFF_FFFF_FFFE_0000));
    // follow-up then sync
    add_fixed(mk(sfp_pkg::MSG_FOLLOW_UP, 1'b0, 1'b1, 16'hFFFF, '0, '0, '1, '1, '1), NO_SAMPLE);
    add_msg(mk(sfp_pkg::MSG_SYNC, 1'b1, 1'b1, 16'hFFFF, '1, '1, '0, '0,
               64'h0123_4567_89AB_CDEF));
    // replacement: same kind twice, then sequence mismatch
    add_fixed(mk(sfp_pkg::MSG_SYNC, 1'b1, 1'b1, 16'd5, 48'd1, 30'd1, 48'd1, 30'd1, 64'd0),
              NO_SAMPLE);
    add_fixed(mk(sfp_pkg::MSG_SYNC, 1'b1, 1'b1, 16'd5, 48'd2, 30'd2, 48'd2, 30'd2, 64'd0),
              NO_SAMPLE);
    add_fixed(mk(sfp_pkg::MSG_FOLLOW_UP, 1'b0, 1'b1, 16'd6, 48'd3, 30'd3, 48'd3, 30'd3, 64'd0),
              NO_SAMPLE);
    add_msg(mk(sfp_pkg::MSG_SYNC, 1'b1, 1'b1, 16'd6, 48'd4, 30'd4, 48'd4, 30'd4, 64'h1_0000));
    // follow-up with the two-step flag set pairs as usual
    add_fixed(mk(sfp_pkg::MSG_FOLLOW_UP, 1'b1, 1'b1, 16'd0, 48'd8, 30'd8, 48'd8, 30'd8, 64'd0),
              NO_SAMPLE);
    add_msg(mk(sfp_pkg::MSG_SYNC, 1'b1, 1'b1, 16'd0, 48'd9, 30'd9, 48'd9, 30'd9, 64'd0));
    // one-step sync drops the held message; foreign sync does not pair
    add_fixed(mk(sfp_pkg::MSG_SYNC, 1'b1, 1'b1, 16'd7, 48'd1, 30'd1, 48'd1, 30'd1, 64'd0),
              NO_SAMPLE);
    add_msg(mk(sfp_pkg::MSG_SYNC, 1'b0, 1'b1, 16'd7, 48'd2, 30'd2, 48'd2, 30'd2, 64'd0));
    add_fixed(mk(sfp_pkg::MSG_FOLLOW_UP, 1'b0, 1'b1, 16'd7, 48'd3, 30'd3, 48'd3, 30'd3, 64'd0),
              NO_SAMPLE);
    add_fixed(mk(sfp_pkg::MSG_SYNC, 1'b1, 1'b0, 16'd7, 48'd4, 30'd4, 48'd4, 30'd4, 64'd0),
              NO_SAMPLE);
    add_msg(mk(sfp_pkg::MSG_SYNC, 1'b1, 1'b1, 16'd7, 48'd5, 30'd5, 48'd5, 30'd5, 64'd0));
    // asymmetry of one nanosecond on a sync
    add_write(sfp_pkg::REG_PATH_ASYM, 64'h1_0000);
    add_fixed(mk(sfp_pkg::MSG_SYNC, 1'b0, 1'b1, 16'd9, '0, '0, '0, '0, '0),
              '{1'b1, 64'd0, 64'd1});

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      row = directed[i];
      if (row.kind == ROW_WRITE) begin
        drain();
        write_reg(row.index, row.data);
      end else begin
        offer_message(row.m, row.fixed, row.want);
      end
    end

    // no asymmetry, with the receiver holding off long enough to fill the block
    drain();
    write_reg(sfp_pkg::REG_PATH_ASYM, 64'd0);
    long_hold = 1'b1;
    run_random(300);

    // largest positive asymmetry, sender pausing midway until all results are back
    drain();
    write_reg(sfp_pkg::REG_PATH_ASYM, 64'h7FFF_FFFF_FFFF_FFFF);
    run_random(120);
    drain();
    run_random(130);

    // most negative asymmetry
    drain();
    write_reg(sfp_pkg::REG_PATH_ASYM, 64'h8000_0000_0000_0000);
    run_random(250);

    // port not receiving
    drain();
    write_reg(sfp_pkg::REG_RECEIVER_STATE, 64'd0);
    write_reg(sfp_pkg::REG_PATH_ASYM, rand_word());
    run_random(40);

    // receiving again with a random asymmetry; no idling at the end
    drain();
    write_reg(sfp_pkg::REG_RECEIVER_STATE, 64'd1);
    run_random(280);
    quiet = 1'b1;
    run_random(110);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_samples.size() == 0) begin
      $display("sync_follow_up_pairing_test: PASS");
    end else begin
      $display("sync_follow_up_pairing_test: FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/sfp_pkg.sv
hdl/sfp_front.sv
hdl/sfp_queue.sv
hdl/sfp_back.sv
hdl/sync_follow_up_pairing.sv
tb/sv/sync_follow_up_pairing_test.sv
